// File: rtl/core/sps_pkg.sv
// Package for the servo poll scheduler: slot geometry, opcode, action,
// status and configuration register codes. No dependencies.
package sps_pkg;

  localparam int SERVO_SLOTS = 256;
  localparam int SLOT_W      = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;
  localparam int CNT_W       = $clog2(SERVO_SLOTS + 1);

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PAROLE_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAROLE_MAX = 1'd1;

  localparam logic [31:0] PAROLE_MIN_RST = 32'd1000;
  localparam logic [31:0] PAROLE_MAX_RST = 32'd60000;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_VOLT_RPLY = 2'd1,
    OP_TEMP_RPLY = 2'd2,
    OP_MARK      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_REQ_VOLT = 2'd1,
    ACT_REQ_TEMP = 2'd2,
    ACT_RECORD   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BUSY_TICK = 2'd1,
    STS_UNEXP     = 2'd2,
    STS_UNUSED    = 2'd3
  } status_t;

endpackage

// File: rtl/core/sps_if.sv
// Valid/ready channel interfaces for the poll scheduler's input and result
// streams. Depends on nothing; widths follow the item fields.
interface sps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         servo_addr;
  logic               replied;
  logic signed [15:0] reading;
  logic [31:0]        now_ms;

  modport source (output valid, opcode, servo_addr, replied, reading, now_ms, input ready);
  modport sink   (input valid, opcode, servo_addr, replied, reading, now_ms, output ready);
endinterface

interface sps_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         target_addr;
  logic signed [15:0] voltage_mv;
  logic signed [15:0] temperature_dc;
  logic [31:0]        last_seen_ms;
  logic [1:0]         status;

  modport source (output valid, action, target_addr, voltage_mv, temperature_dc,
                  last_seen_ms, status, input ready);
  modport sink   (input valid, action, target_addr, voltage_mv, temperature_dc,
                  last_seen_ms, status, output ready);
endinterface

// File: rtl/core/servo_poll_scheduler_backoff_core.sv
// Round-robin servo poller with exponential parole backoff.
// Depends on sps_pkg and the sps_in_if / sps_out_if channel interfaces.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------
//  in_ch    | in  | valid/ready     | opcode, servo_addr, replied, reading, now_ms
//  out_ch   | out | valid/ready     | action, target_addr, voltage_mv,
//           |     |                 | temperature_dc, last_seen_ms, status
//  cfg_*    | in  | cfg_we only     | cfg_idx, cfg_wdata (parole min / max)
//
// Each item is accepted while idle, decoded, and its result is then emitted.
// An idle poll tick scans one slot per cycle through the retry-time memory
// read port, over at most SERVO_SLOTS slots. A missed reply adds the steps
// read / double-and-clamp / add-and-saturate on the shared 33-bit adder.
// Reset (rst_n, synchronous) clears the presence and parole bits at once; no
// memory sweep is needed. in_ch.ready is high only while idle; a result
// waiting on out_ch holds the block in its emit step until transferred.
module servo_poll_scheduler_backoff_core
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sps_in_if.sink                in_ch,
  sps_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // One-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DECODE   = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_MISS_RD  = 7'b0001000,
    ST_MISS_DBL = 7'b0010000,
    ST_MISS_ADD = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] parole_min_r, parole_min_nxt;
  logic [31:0] parole_max_r, parole_max_nxt;

  // poller control state
  logic [SERVO_SLOTS-1:0] present_r, present_nxt;
  logic [SERVO_SLOTS-1:0] retry_vld_r, retry_vld_nxt;
  logic [SLOT_W-1:0]      last_polled_r, last_polled_nxt;
  logic                   have_last_r, have_last_nxt;
  logic                   ask_temp_r, ask_temp_nxt;
  logic                   waiting_r, waiting_nxt;

  // latched input item
  opcode_t            op_r, op_nxt;
  logic [7:0]         addr_r, addr_nxt;
  logic               replied_r, replied_nxt;
  logic signed [15:0] reading_r, reading_nxt;
  logic [31:0]        now_r, now_nxt;

  // voltage of the servo being polled; the record only ever reports the
  // voltage taken in the same poll round, so one holding register covers it
  logic signed [15:0] volt_hold_r, volt_hold_nxt;

  // scan pipeline: issue stage drives the memory address, check stage
  // compares the registered retry time
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic [SLOT_W-1:0] p_slot_r, p_slot_nxt;
  logic              p_imm_r, p_imm_nxt;
  logic              p_chk_r, p_chk_nxt;

  // backoff arithmetic
  logic [31:0] base_r, base_nxt;
  logic [31:0] bo_new_r, bo_new_nxt;

  // result staging and output register
  action_t            res_action_r, res_action_nxt;
  logic [7:0]         res_target_r, res_target_nxt;
  logic signed [15:0] res_volt_r, res_volt_nxt;
  logic signed [15:0] res_temp_r, res_temp_nxt;
  logic [31:0]        res_seen_r, res_seen_nxt;
  status_t            res_status_r, res_status_nxt;

  logic               out_valid_r, out_valid_nxt;
  action_t            out_action_r, out_action_nxt;
  logic [7:0]         out_target_r, out_target_nxt;
  logic signed [15:0] out_volt_r, out_volt_nxt;
  logic signed [15:0] out_temp_r, out_temp_nxt;
  logic [31:0]        out_seen_r, out_seen_nxt;
  status_t            out_status_r, out_status_nxt;

  // retry time and backoff memories, one read port each, registered data
  logic [31:0] rt_mem [SERVO_SLOTS];
  logic [31:0] bo_mem [SERVO_SLOTS];
  logic [31:0] rt_rd_r;
  logic [31:0] bo_rd_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              mem_we;
  logic [31:0]       rt_wdata;

  // shared adder / comparator
  logic [32:0] unit_a;
  logic [32:0] unit_b;
  logic        unit_sub;
  logic [33:0] unit_sum;
  logic        unit_no_borrow;
  logic        unit_carry32;

  logic [SLOT_W-1:0] scan_base;
  logic              scan_hit;
  logic              restart;

  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.action         = out_action_r;
  assign out_ch.target_addr    = out_target_r;
  assign out_ch.voltage_mv     = out_volt_r;
  assign out_ch.temperature_dc = out_temp_r;
  assign out_ch.last_seen_ms   = out_seen_r;
  assign out_ch.status         = out_status_r;

  // ---------------------------------------------------------------------
  // Shared arithmetic unit: subtract for compares, add for retry time
  // ---------------------------------------------------------------------
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    case (state_r)
      ST_SCAN: begin
        // rt - now borrows exactly when now > rt
        unit_a   = {1'b0, rt_rd_r};
        unit_b   = {1'b0, now_r};
        unit_sub = 1'b1;
      end
      ST_MISS_DBL: begin
        // max - 2*backoff borrows when the doubled backoff exceeds the cap
        unit_a   = {1'b0, parole_max_r};
        unit_b   = {bo_rd_r, 1'b0};
        unit_sub = 1'b1;
      end
      ST_MISS_ADD: begin
        unit_a   = {1'b0, base_r};
        unit_b   = {1'b0, bo_new_r};
        unit_sub = 1'b0;
      end
      default: begin
        unit_sub = 1'b0;
      end
    endcase
  end

  assign unit_sum       = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                          + 34'(unit_sub);
  assign unit_no_borrow = unit_sum[33];
  assign unit_carry32   = unit_sum[32];

  assign rt_wdata = unit_carry32 ? 32'hFFFF_FFFF : unit_sum[31:0];

  assign scan_base = !have_last_r ? '0 :
                     (last_polled_r == SLOT_W'(SERVO_SLOTS - 1)) ? '0 :
                     last_polled_r + 1'b1;

  assign scan_hit = p_vld_r && (p_imm_r || (p_chk_r && !unit_no_borrow));
  assign restart  = (bo_rd_r == '0) || !retry_vld_r[last_polled_r];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    parole_min_nxt  = parole_min_r;
    parole_max_nxt  = parole_max_r;
    present_nxt     = present_r;
    retry_vld_nxt   = retry_vld_r;
    last_polled_nxt = last_polled_r;
    have_last_nxt   = have_last_r;
    ask_temp_nxt    = ask_temp_r;
    waiting_nxt     = waiting_r;
    op_nxt          = op_r;
    addr_nxt        = addr_r;
    replied_nxt     = replied_r;
    reading_nxt     = reading_r;
    now_nxt         = now_r;
    volt_hold_nxt   = volt_hold_r;
    scan_idx_nxt    = scan_idx_r;
    scan_cnt_nxt    = scan_cnt_r;
    p_vld_nxt       = p_vld_r;
    p_slot_nxt      = p_slot_r;
    p_imm_nxt       = p_imm_r;
    p_chk_nxt       = p_chk_r;
    base_nxt        = base_r;
    bo_new_nxt      = bo_new_r;
    res_action_nxt  = res_action_r;
    res_target_nxt  = res_target_r;
    res_volt_nxt    = res_volt_r;
    res_temp_nxt    = res_temp_r;
    res_seen_nxt    = res_seen_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_action_nxt  = out_action_r;
    out_target_nxt  = out_target_r;
    out_volt_nxt    = out_volt_r;
    out_temp_nxt    = out_temp_r;
    out_seen_nxt    = out_seen_r;
    out_status_nxt  = out_status_r;
    rd_addr         = scan_idx_r;
    mem_we          = 1'b0;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_PAROLE_MIN: parole_min_nxt = cfg_wdata;
        CFG_PAROLE_MAX: parole_max_nxt = cfg_wdata;
        default:        parole_min_nxt = parole_min_r;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = opcode_t'(in_ch.opcode);
          addr_nxt    = in_ch.servo_addr;
          replied_nxt = in_ch.replied;
          reading_nxt = in_ch.reading;
          now_nxt     = in_ch.now_ms;
          state_nxt   = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_action_nxt = ACT_NONE;
        res_target_nxt = '0;
        res_volt_nxt   = '0;
        res_temp_nxt   = '0;
        res_seen_nxt   = '0;
        res_status_nxt = STS_OK;
        state_nxt      = ST_EMIT;
        case (op_r)
          OP_TICK: begin
            if (waiting_r) begin
              res_status_nxt = STS_BUSY_TICK;
            end else if (ask_temp_r) begin
              waiting_nxt    = 1'b1;
              res_action_nxt = ACT_REQ_TEMP;
              res_target_nxt = 8'(last_polled_r);
            end else begin
              scan_idx_nxt = scan_base;
              scan_cnt_nxt = '0;
              p_vld_nxt    = 1'b0;
              state_nxt    = ST_SCAN;
            end
          end
          OP_VOLT_RPLY: begin
            if (!waiting_r || ask_temp_r) begin
              res_status_nxt = STS_UNEXP;
            end else begin
              waiting_nxt = 1'b0;
              if (replied_r) begin
                retry_vld_nxt[last_polled_r] = 1'b0;
                volt_hold_nxt                = reading_r;
                ask_temp_nxt                 = 1'b1;
              end else begin
                state_nxt = ST_MISS_RD;
              end
            end
          end
          OP_TEMP_RPLY: begin
            if (!waiting_r || !ask_temp_r) begin
              res_status_nxt = STS_UNEXP;
            end else begin
              waiting_nxt = 1'b0;
              if (replied_r) begin
                retry_vld_nxt[last_polled_r] = 1'b0;
                ask_temp_nxt                 = 1'b0;
                res_action_nxt               = ACT_RECORD;
                res_target_nxt               = 8'(last_polled_r);
                res_volt_nxt                 = volt_hold_r;
                res_temp_nxt                 = reading_r;
                res_seen_nxt                 = now_r;
              end else begin
                state_nxt = ST_MISS_RD;
              end
            end
          end
          OP_MARK: begin
            if ({1'b0, addr_r} < 9'(SERVO_SLOTS)) begin
              present_nxt[addr_r[SLOT_W-1:0]] = 1'b1;
            end
          end
          default: begin
            res_status_nxt = STS_OK;
          end
        endcase
      end

      ST_SCAN: begin
        // issue stage
        if (scan_cnt_r < CNT_W'(SERVO_SLOTS)) begin
          p_vld_nxt    = 1'b1;
          p_slot_nxt   = scan_idx_r;
          p_imm_nxt    = present_r[scan_idx_r] && !retry_vld_r[scan_idx_r];
          p_chk_nxt    = present_r[scan_idx_r] && retry_vld_r[scan_idx_r];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          scan_idx_nxt = (scan_idx_r == SLOT_W'(SERVO_SLOTS - 1)) ? '0
                                                                   : scan_idx_r + 1'b1;
        end else begin
          p_vld_nxt = 1'b0;
        end
        // check stage
        if (scan_hit) begin
          last_polled_nxt = p_slot_r;
          have_last_nxt   = 1'b1;
          waiting_nxt     = 1'b1;
          res_action_nxt  = ACT_REQ_VOLT;
          res_target_nxt  = 8'(p_slot_r);
          state_nxt       = ST_EMIT;
        end else if (!p_vld_r && (scan_cnt_r == CNT_W'(SERVO_SLOTS))) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_MISS_RD: begin
        rd_addr   = last_polled_r;
        state_nxt = ST_MISS_DBL;
      end

      ST_MISS_DBL: begin
        if (restart) begin
          bo_new_nxt = parole_min_r;
          base_nxt   = now_r;
        end else begin
          base_nxt   = rt_rd_r;
          bo_new_nxt = unit_no_borrow ? {bo_rd_r[30:0], 1'b0} : parole_max_r;
        end
        state_nxt = ST_MISS_ADD;
      end

      ST_MISS_ADD: begin
        mem_we                       = 1'b1;
        retry_vld_nxt[last_polled_r] = 1'b1;
        ask_temp_nxt                 = 1'b0;
        state_nxt                    = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = res_action_r;
          out_target_nxt = res_target_r;
          out_volt_nxt   = res_volt_r;
          out_temp_nxt   = res_temp_r;
          out_seen_nxt   = res_seen_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      parole_min_r  <= PAROLE_MIN_RST;
      parole_max_r  <= PAROLE_MAX_RST;
      present_r     <= '0;
      retry_vld_r   <= '0;
      last_polled_r <= '0;
      have_last_r   <= 1'b0;
      ask_temp_r    <= 1'b0;
      waiting_r     <= 1'b0;
      scan_cnt_r    <= '0;
      p_vld_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      parole_min_r  <= parole_min_nxt;
      parole_max_r  <= parole_max_nxt;
      present_r     <= present_nxt;
      retry_vld_r   <= retry_vld_nxt;
      last_polled_r <= last_polled_nxt;
      have_last_r   <= have_last_nxt;
      ask_temp_r    <= ask_temp_nxt;
      waiting_r     <= waiting_nxt;
      scan_cnt_r    <= scan_cnt_nxt;
      p_vld_r       <= p_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    replied_r    <= replied_nxt;
    reading_r    <= reading_nxt;
    now_r        <= now_nxt;
    volt_hold_r  <= volt_hold_nxt;
    scan_idx_r   <= scan_idx_nxt;
    p_slot_r     <= p_slot_nxt;
    p_imm_r      <= p_imm_nxt;
    p_chk_r      <= p_chk_nxt;
    base_r       <= base_nxt;
    bo_new_r     <= bo_new_nxt;
    res_action_r <= res_action_nxt;
    res_target_r <= res_target_nxt;
    res_volt_r   <= res_volt_nxt;
    res_temp_r   <= res_temp_nxt;
    res_seen_r   <= res_seen_nxt;
    res_status_r <= res_status_nxt;
    out_action_r <= out_action_nxt;
    out_target_r <= out_target_nxt;
    out_volt_r   <= out_volt_nxt;
    out_temp_r   <= out_temp_nxt;
    out_seen_r   <= out_seen_nxt;
    out_status_r <= out_status_nxt;
  end

  // retry time / backoff memories; entries are only used while the slot's
  // parole bit is set, and that bit is set by the step that writes the entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rt_mem[last_polled_r] <= rt_wdata;
      bo_mem[last_polled_r] <= bo_new_r;
    end
    rt_rd_r <= rt_mem[rd_addr];
    bo_rd_r <= bo_mem[rd_addr];
  end

endmodule

// File: rtl/core/sps_checker.sv
// Port-level checks for the servo poll scheduler, bound to the top level.
// Depends on sps_pkg for action and status codes.
module sps_checker
  import sps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_action,
  input logic [7:0]  out_target,
  input logic [15:0] out_volt,
  input logic [15:0] out_temp,
  input logic [31:0] out_seen,
  input logic [1:0]  out_status
);

  // a stalled result keeps its action and target
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_target))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // a non-ok status never carries an action
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> (out_action == ACT_NONE))
    else $error("action reported with an error status");

  // an empty action carries an all-zero record
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_NONE) |->
      (out_target == '0) && (out_volt == '0) && (out_temp == '0) && (out_seen == '0))
    else $error("empty action with nonzero fields");

  // record fields only travel with a completed record
  a_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_RECORD) |-> (out_seen == '0) && (out_status != STS_UNUSED))
    else $error("request carries record data or bad status");

endmodule

bind servo_poll_scheduler_backoff_core sps_checker u_sps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_action (out_ch.action),
  .out_target (out_ch.target_addr),
  .out_volt   (out_ch.voltage_mv),
  .out_temp   (out_ch.temperature_dc),
  .out_seen   (out_ch.last_seen_ms),
  .out_status (out_ch.status)
);

// File: tb/sv/tb_servo_poll_scheduler_backoff_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for servo_poll_scheduler_backoff_core: directed and random
// poll traffic with a built-in scheduler predictor. Depends on sps_pkg and sps_if.
module tb_servo_poll_scheduler_backoff_core;
  import sps_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // Worst legal quiet stretch: the long output hold plus a full scan.
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int LONG_HOLD       = 300;
  // Idle cycles after the last result before a register write or the verdict.
  localparam int SETTLE_CYCLES   = 10;

  typedef struct {
    opcode_t            op;
    logic [7:0]         addr;
    logic               replied;
    logic signed [15:0] reading;
    logic [31:0]        now;
  } poll_item_t;

  typedef struct {
    action_t            act;
    logic [7:0]         target;
    logic signed [15:0] volt;
    logic signed [15:0] temp;
    logic [31:0]        seen;
    status_t            sts;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sps_in_if  in_ch();
  sps_out_if out_ch();

  servo_poll_scheduler_backoff_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Scheduler predictor state (mirrors the block's tables and mode bits)
  // ---------------------------------------------------------------------------
  bit                 slot_present [SERVO_SLOTS];
  logic signed [15:0] volt_mem     [SERVO_SLOTS];
  logic signed [15:0] temp_mem     [SERVO_SLOTS];
  logic [31:0]        seen_mem     [SERVO_SLOTS];
  bit                 parole_on    [SERVO_SLOTS];
  logic [31:0]        retry_at     [SERVO_SLOTS];
  logic [31:0]        backoff_cur  [SERVO_SLOTS];
  logic [SLOT_W-1:0]  last_slot;
  bit                 polled_once;
  bit                 temp_phase;     // next tick asks for temperature
  bit                 reply_pending;  // a request is outstanding
  logic [31:0]        min_backoff;
  logic [31:0]        max_backoff;

  outcome_t    outcome_q[$];   // predicted results, oldest first
  int          errors;
  logic [31:0] clock_ms;       // running time base for random traffic
  bit          quiet;          // no idling on either side while set
  int          holds_asked;
  int          holds_served;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic clear_predictor();
    for (int i = 0; i < SERVO_SLOTS; i++) begin
      slot_present[i] = 1'b0;
      volt_mem[i]     = '0;
      temp_mem[i]     = '0;
      seen_mem[i]     = '0;
      parole_on[i]    = 1'b0;
      retry_at[i]     = '0;
      backoff_cur[i]  = '0;
    end
    last_slot     = '0;
    polled_once   = 1'b0;
    temp_phase    = 1'b0;
    reply_pending = 1'b0;
    min_backoff   = PAROLE_MIN_RST;
    max_backoff   = PAROLE_MAX_RST;
  endtask

  function automatic void note_found(int s, logic [31:0] now);
    backoff_cur[s] = '0;
    parole_on[s]   = 1'b0;
    seen_mem[s]    = now;
  endfunction

  // Missed reply: restart or double the backoff, then push the retry time out.
  function automatic void note_miss(int s, logic [31:0] now);
    logic [32:0] doubled;
    logic [32:0] sum;
    if (backoff_cur[s] == 0 || !parole_on[s]) begin
      backoff_cur[s] = min_backoff;
      retry_at[s]    = now;
    end else begin
      doubled        = {backoff_cur[s], 1'b0};
      backoff_cur[s] = (doubled > {1'b0, max_backoff}) ? max_backoff : doubled[31:0];
    end
    sum         = {1'b0, retry_at[s]} + {1'b0, backoff_cur[s]};
    retry_at[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    parole_on[s] = 1'b1;
    temp_phase   = 1'b0;
  endfunction

  function automatic outcome_t poll_step(poll_item_t it);
    outcome_t r;
    int       cur;
    int       base;
    int       s;
    int       pick;
    bit       found;
    r     = '{ACT_NONE, 8'd0, 16'sd0, 16'sd0, 32'd0, STS_OK};
    cur   = int'(last_slot);
    found = 1'b0;
    pick  = 0;
    case (it.op)
      OP_TICK: begin
        if (reply_pending) begin
          r.sts = STS_BUSY_TICK;
        end else if (temp_phase) begin
          reply_pending = 1'b1;
          r.act         = ACT_REQ_TEMP;
          r.target      = cur[7:0];
        end else begin
          // Round robin from the slot after the last one polled.
          base = polled_once ? (cur + 1) % SERVO_SLOTS : 0;
          for (int k = 0; k < SERVO_SLOTS; k++) begin
            s = (base + k) % SERVO_SLOTS;
            if (!found && slot_present[s] && (!parole_on[s] || it.now > retry_at[s])) begin
              found = 1'b1;
              pick  = s;
            end
          end
          if (found) begin
            last_slot     = pick[SLOT_W-1:0];
            polled_once   = 1'b1;
            reply_pending = 1'b1;
            r.act         = ACT_REQ_VOLT;
            r.target      = pick[7:0];
          end
        end
      end
      OP_VOLT_RPLY: begin
        if (!reply_pending || temp_phase) begin
          r.sts = STS_UNEXP;
        end else begin
          reply_pending = 1'b0;
          if (it.replied) begin
            note_found(cur, it.now);
            volt_mem[cur] = it.reading;
            temp_phase    = 1'b1;
          end else begin
            note_miss(cur, it.now);
          end
        end
      end
      OP_TEMP_RPLY: begin
        if (!reply_pending || !temp_phase) begin
          r.sts = STS_UNEXP;
        end else begin
          reply_pending = 1'b0;
          if (it.replied) begin
            note_found(cur, it.now);
            temp_mem[cur] = it.reading;
            temp_phase    = 1'b0;
            r.act         = ACT_RECORD;
            r.target      = cur[7:0];
            r.volt        = volt_mem[cur];
            r.temp        = temp_mem[cur];
            r.seen        = seen_mem[cur];
          end else begin
            note_miss(cur, it.now);
          end
        end
      end
      default: begin
        if (int'(it.addr) < SERVO_SLOTS) slot_present[it.addr] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic poll_item_t make_item(opcode_t op, logic [7:0] addr, logic replied,
                                           logic signed [15:0] reading, logic [31:0] now);
    poll_item_t it;
    it.op      = op;
    it.addr    = addr;
    it.replied = replied;
    it.reading = reading;
    it.now     = now;
    return it;
  endfunction

  // Random traffic that mostly follows the request/reply protocol, so the
  // temperature and backoff paths are reached, with stray items mixed in.
  function automatic poll_item_t next_item();
    poll_item_t it;
    int         roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 400);
    it.now     = clock_ms;
    it.addr    = 8'($urandom_range(0, 255));
    it.replied = ($urandom_range(0, 99) < 70);
    it.reading = 16'($urandom);
    if (reply_pending && !temp_phase) begin
      if (roll < 85) it.op = OP_VOLT_RPLY;
      else if (roll < 90) it.op = OP_TICK;
      else if (roll < 95) it.op = OP_TEMP_RPLY;
      else it.op = OP_MARK;
    end else if (reply_pending) begin
      if (roll < 85) it.op = OP_TEMP_RPLY;
      else if (roll < 90) it.op = OP_TICK;
      else if (roll < 95) it.op = OP_VOLT_RPLY;
      else it.op = OP_MARK;
    end else begin
      if (roll < 75) it.op = OP_TICK;
      else if (roll < 90) it.op = OP_MARK;
      else if (roll < 95) it.op = OP_VOLT_RPLY;
      else it.op = OP_TEMP_RPLY;
    end
    return it;
  endfunction

  // Drive at the falling edge, hold until the transfer, then predict.
  task automatic send_item(input poll_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.opcode     = it.op;
    in_ch.servo_addr = it.addr;
    in_ch.replied    = it.replied;
    in_ch.reading    = it.reading;
    in_ch.now_ms     = it.now;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    outcome_q.insert(outcome_q.size(), poll_step(it));
  endtask

  // Stop offering, wait for every predicted result, then let the block settle.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == CFG_PAROLE_MIN) min_backoff = value;
    else max_backoff = value;
  endtask

  task automatic set_parole(input logic [31:0] min_ms, input logic [31:0] max_ms);
    wait_for_results();
    write_reg(CFG_PAROLE_MIN, min_ms);
    write_reg(CFG_PAROLE_MAX, max_ms);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Nothing present: a tick finds nothing, replies are unexpected.
  task automatic test_no_servos();
    send_item(make_item(OP_TICK, 8'd0, 1'b1, 16'sd0, 32'd0));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b1, 16'sd5, 32'd1));
    send_item(make_item(OP_TEMP_RPLY, 8'd0, 1'b1, 16'sd5, 32'd2));
  endtask

  // Huge minimum: doubling overflows 32 bits and clamps, retry add saturates.
  // Slot 128 ends up parked at the all-ones retry time for the rest of the run.
  task automatic test_backoff_limits();
    set_parole(32'h9000_0000, 32'hFFFF_FFFF);
    send_item(make_item(OP_MARK, 8'd128, 1'b0, 16'sd0, 32'd0));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd0));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b0, 16'sd0, 32'd0));
    // retry time equals now: not yet eligible
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'h9000_0000));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'h9000_0001));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b0, 16'sd0, 32'h9000_0001));
  endtask

  // Full voltage/temperature exchange with busy ticks and stray replies.
  task automatic test_request_cycle();
    set_parole(PAROLE_MIN_RST, PAROLE_MAX_RST);
    send_item(make_item(OP_MARK, 8'd0, 1'b0, 16'sd0, 32'd0));
    send_item(make_item(OP_MARK, 8'd255, 1'b0, 16'sd0, 32'd0));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd10));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd11));
    send_item(make_item(OP_TEMP_RPLY, 8'd0, 1'b1, 16'sd7, 32'd12));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b1, -16'sd32768, 32'd13));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd14));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b1, 16'sd9, 32'd15));
    send_item(make_item(OP_TEMP_RPLY, 8'd0, 1'b1, 16'sd32767, 32'hFFFF_FFFF));
  endtask

  // Parole entry, nothing eligible, retry strictly after the retry time,
  // doubling, and a good reply clearing the parole.
  task automatic test_parole();
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd100));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b0, 16'sd0, 32'd100));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd200));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b0, 16'sd0, 32'd200));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd1100));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd1101));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b0, 16'sd0, 32'd1101));
    send_item(make_item(OP_TICK, 8'd0, 1'b0, 16'sd0, 32'd1201));
    send_item(make_item(OP_VOLT_RPLY, 8'd0, 1'b1, 16'sd1234, 32'd1201));
  endtask

  task automatic run_random(input int count, input logic [31:0] min_ms,
                            input logic [31:0] max_ms, input bit no_idle);
    set_parole(min_ms, max_ms);
    quiet = no_idle;
    repeat (count) send_item(next_item());
    quiet = 1'b0;
  endtask

  // Result side stalls for a long stretch while items keep coming, so the
  // block backs up and drops in_ch.ready.
  task automatic test_output_hold();
    wait_for_results();
    holds_asked++;
    repeat (8) send_item(next_item());
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random ready stalls, plus the long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    stall        = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_served++;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        out_ch.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, tag, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result transfer: action %0d target %0d status %0d",
                 $time, out_ch.action, out_ch.target_addr, out_ch.status);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        compare_field("action", 32'(want.act), 32'(out_ch.action));
        compare_field("target_addr", 32'(want.target), 32'(out_ch.target_addr));
        compare_field("voltage_mv", 32'(want.volt[15:0]), 32'(out_ch.voltage_mv[15:0]));
        compare_field("temperature_dc", 32'(want.temp[15:0]),
                      32'(out_ch.temperature_dc[15:0]));
        compare_field("last_seen_ms", want.seen, out_ch.last_seen_ms);
        compare_field("status", 32'(want.sts), 32'(out_ch.status));
      end
    end
  end

  // Hang detection: count cycles without a transfer on either channel.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = '0;
    in_ch.servo_addr = '0;
    in_ch.replied    = 1'b0;
    in_ch.reading    = '0;
    in_ch.now_ms     = '0;
    errors           = 0;
    quiet            = 1'b0;
    holds_asked      = 0;
    clock_ms         = 32'd2000;
    clear_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed
    test_no_servos();
    test_backoff_limits();
    test_request_cycle();
    test_parole();

    // random, one backoff setting per phase; the all-ones minimum goes last
    // since every miss under it parks the slot for good
    run_random(300, PAROLE_MIN_RST, PAROLE_MAX_RST, 1'b0);
    run_random(200, 32'd1, 32'd1, 1'b1);
    test_output_hold();
    run_random(300, $urandom_range(1, 5000), $urandom_range(1, 5000), 1'b0);
    run_random(300, 32'd1, 32'hFFFF_FFFF, 1'b0);
    run_random(120, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    wait_for_results();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: servo_poll_scheduler_backoff_core.f
rtl/core/sps_pkg.sv
rtl/core/sps_if.sv
rtl/core/servo_poll_scheduler_backoff_core.sv
rtl/core/sps_checker.sv
tb/sv/tb_servo_poll_scheduler_backoff_core.sv
